>>> rtl/core/periodic_and_oneshot_timer_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer table unit
// Concurrent checks are clocked by clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_AND_ONESHOT_TIMER_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_AND_ONESHOT_TIMER_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that cond holds at every clock edge outside reset.
`define POTT_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Check that cons holds in the same cycle whenever ante holds.
`define POTT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define POTT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define POTT_ASSERT_ALWAYS(label, cond)
`define POTT_ASSERT_IMPLIES(label, ante, cons)
`define POTT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/pott_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, codes, item and table entry types used by the timer table unit.
// ----------------------------------------------------------------------------
package pott_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_TICK         = 2'd0,
		OP_ADD_PERIODIC = 2'd1,
		OP_ADD_ONESHOT  = 2'd2,
		OP_UNUSED       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_FIRED  = 2'd2,
		KIND_IDLE   = 2'd3
	} kind_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  timer_id;
		logic [31:0] tick_count;
	} req_item_t;

	typedef struct packed {
		kind_t      result_kind;
		logic [7:0] fired_id;
		logic       last;
	} rsp_item_t;

	// One table slot; a reload of zero marks a one-shot timer.
	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] reload;
		logic [31:0] remaining;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/periodic_and_oneshot_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Periodic and one-shot timer table unit
// Add: the result is registered in the cycle after accept; the next item may
// follow once the result register frees up. Tick: the walk reads the live
// entries through the table RAM port into the shared decrement/compare unit,
// one entry per cycle unless a held fire waits on a stalled result side;
// the last result is registered from ST_FINISH. One item at a time.
// arst_n clears the live count and sequencer, not the RAM.
// ----------------------------------------------------------------------------
`include "periodic_and_oneshot_timer_table_unit_assert.svh"

module periodic_and_oneshot_timer_table_unit import pott_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] live_q;     // number of live table entries
	logic [CNT_W-1:0] rd_idx_q;   // next entry to read during a walk
	logic [CNT_W-1:0] wr_idx_q;   // next compacted slot to write back
	logic [IDX_W-1:0] ev_idx_s1;  // entry whose data sits at the RAM output
	logic             ev_vld_s1;  // RAM output holds an entry to evaluate
	logic             pend_vld_q; // a fired result is held back for "last"
	logic [7:0]       pend_id_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	// RAM port signals
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic        out_free;
	logic        req_fire;
	logic        is_add;
	logic        table_full;
	logic [31:0] load;
	entry_t      ev;
	entry_t      add_entry;
	entry_t      walk_entry;
	logic [31:0] rem_dec;
	logic        fire;
	logic        keep;
	logic        walk_more;
	logic        emit_prev;
	logic        adv;

	pott_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The result register frees up when empty or when its item is taken now.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign req_fire  = req_valid && !req_stall;

	assign is_add     = (req.operation == OP_ADD_PERIODIC) || (req.operation == OP_ADD_ONESHOT);
	assign table_full = (live_q == CNT_W'(MAX_ENTRIES));
	// A zero period or delay counts as one tick.
	assign load       = (req.tick_count == 32'd0) ? 32'd1 : req.tick_count;

	always_comb begin
		add_entry.id        = req.timer_id;
		add_entry.reload    = (req.operation == OP_ADD_PERIODIC) ? load : 32'd0;
		add_entry.remaining = load;
	end

	// Shared decrement and zero compare on the entry at the RAM output.
	assign ev        = entry_t'(ram_rdata);
	assign rem_dec   = (ev.remaining == 32'd0) ? 32'd0 : ev.remaining - 32'd1;
	assign fire      = (rem_dec == 32'd0);
	// Drop a fired one-shot; everything else is written back compacted.
	assign keep      = !fire || (ev.reload != 32'd0);
	assign walk_more = (rd_idx_q < live_q);
	// A new fire pushes the held-back fire out; that needs the result register.
	assign emit_prev = ev_vld_s1 && fire && pend_vld_q;
	assign adv       = !emit_prev || out_free;

	always_comb begin
		walk_entry.id        = ev.id;
		walk_entry.reload    = ev.reload;
		walk_entry.remaining = fire ? ev.reload : rem_dec;
	end

	always_comb begin
		if (state_q == ST_WALK) begin
			ram_we    = adv && ev_vld_s1 && keep;
			ram_waddr = wr_idx_q[IDX_W-1:0];
			ram_wdata = ENTRY_W'(walk_entry);
		end else begin
			ram_we    = req_fire && is_add && !table_full;
			ram_waddr = live_q[IDX_W-1:0];
			ram_wdata = ENTRY_W'(add_entry);
		end
		// On a stall re-read the entry under evaluation so its data holds.
		ram_raddr = adv ? rd_idx_q[IDX_W-1:0] : ev_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			live_q      <= '0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			ev_idx_s1   <= '0;
			ev_vld_s1   <= 1'b0;
			pend_vld_q  <= 1'b0;
			pend_id_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// Drop the result once it is taken; a new one may overwrite below.
			if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (is_add) begin
							rsp_valid_q       <= 1'b1;
							rsp_q.fired_id    <= '0;
							rsp_q.last        <= 1'b1;
							if (table_full) begin
								rsp_q.result_kind <= KIND_FULL;
							end else begin
								rsp_q.result_kind <= KIND_ACCEPT;
								live_q            <= live_q + CNT_W'(1);
							end
						end else if (req.operation == OP_TICK) begin
							rd_idx_q   <= '0;
							wr_idx_q   <= '0;
							ev_vld_s1  <= 1'b0;
							pend_vld_q <= 1'b0;
							state_q    <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (adv) begin
						// Issue the next read while evaluating the current entry.
						if (walk_more) begin
							rd_idx_q  <= rd_idx_q + CNT_W'(1);
							ev_idx_s1 <= rd_idx_q[IDX_W-1:0];
							ev_vld_s1 <= 1'b1;
						end else begin
							ev_vld_s1 <= 1'b0;
						end
						if (ev_vld_s1) begin
							if (keep) begin
								wr_idx_q <= wr_idx_q + CNT_W'(1);
							end
							if (fire) begin
								pend_vld_q <= 1'b1;
								pend_id_q  <= ev.id;
								if (pend_vld_q) begin
									rsp_valid_q       <= 1'b1;
									rsp_q.result_kind <= KIND_FIRED;
									rsp_q.fired_id    <= pend_id_q;
									rsp_q.last        <= 1'b0;
								end
							end
						end else if (!walk_more) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					// Emit the held fire as the final result, or report a quiet tick.
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q.last  <= 1'b1;
						if (pend_vld_q) begin
							rsp_q.result_kind <= KIND_FIRED;
							rsp_q.fired_id    <= pend_id_q;
						end else begin
							rsp_q.result_kind <= KIND_IDLE;
							rsp_q.fired_id    <= '0;
						end
						live_q     <= wr_idx_q;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`POTT_ASSERT_ALWAYS(a_live_bound, live_q <= CNT_W'(MAX_ENTRIES))
	`POTT_ASSERT_IMPLIES(a_compact_order, state_q == ST_WALK, wr_idx_q <= rd_idx_q)
	`POTT_ASSERT_IMPLIES(a_rd_bound, state_q == ST_WALK, rd_idx_q <= live_q)
	`POTT_ASSERT_IMPLIES(a_id_zero, rsp_valid && rsp.result_kind != KIND_FIRED, rsp.fired_id == 8'd0)
	`POTT_ASSERT_NEXT(a_finish_done, state_q == ST_FINISH && out_free, state_q == ST_IDLE && rsp_valid && rsp.last)

endmodule

>>> rtl/core/pott_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module pott_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
